FILE: rtl/core/isq_pkg.sv
// isq_pkg: shared types, codes and defaults for the indexed sequence store
// depends on nothing; used by every module of the block
package isq_pkg;

    localparam int CAPACITY_DEF = 64;

    // request actions
    localparam logic [2:0] ACT_READ      = 3'd0;
    localparam logic [2:0] ACT_INS_FRONT = 3'd1;
    localparam logic [2:0] ACT_APPEND    = 3'd2;
    localparam logic [2:0] ACT_INS_AT    = 3'd3;
    localparam logic [2:0] ACT_DELETE    = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_READ = 2'd1,
        OP_INS  = 2'd2,
        OP_DEL  = 2'd3
    } op_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [6:0]         position;
        logic signed [31:0] item_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         length_now;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic decode;
        logic mem_rd;
        logic shift_wr;
        logic commit;
        logic load_out;
    } isq_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  dec_op;
        logic more;
    } isq_stat_t;

endpackage

FILE: rtl/core/isq_datapath.sv
// isq_datapath: request register, length, shift pointer, entry memory and result register
// depends on isq_pkg
module isq_datapath #(
    parameter int CAPACITY = isq_pkg::CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  isq_pkg::in_word_t    s_word,
    input  isq_pkg::isq_cmd_t    cmd,
    output isq_pkg::isq_stat_t   stat,
    output isq_pkg::out_word_t   m_word
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int W     = (LEN_W > 7) ? LEN_W : 7;

    logic [31:0]         mem [CAPACITY];
    logic [31:0]         rd_data_reg;

    isq_pkg::in_word_t   req_reg;
    isq_pkg::op_t        op_reg;
    logic [1:0]          st_reg;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    ptr_reg, ptr_next;
    logic [LEN_W-1:0]    p_reg;
    isq_pkg::out_word_t  out_reg;

    logic [W-1:0]        pos_w, len_w, p_w;
    isq_pkg::op_t        dec_op;
    logic [1:0]          dec_st;
    logic [LEN_W:0]      ptr_ext;
    logic [LEN_W-1:0]    ptr_m1, ptr_p1;
    logic [IDX_W-1:0]    raddr, waddr;
    logic [31:0]         wdata;
    logic                we;

    assign pos_w   = W'(req_reg.position);
    assign len_w   = W'(len_reg);
    assign ptr_ext = {1'b0, ptr_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign ptr_p1  = ptr_ext[LEN_W-1:0];
    assign ptr_m1  = ptr_reg - {{(LEN_W-1){1'b0}}, 1'b1};

    // request decode against the current length
    always_comb begin
        dec_op = isq_pkg::OP_NONE;
        dec_st = isq_pkg::ST_DONE;
        p_w    = pos_w;
        unique case (req_reg.action) inside
            isq_pkg::ACT_READ: begin
                if (pos_w < len_w) dec_op = isq_pkg::OP_READ;
                else               dec_st = isq_pkg::ST_RANGE;
            end
            isq_pkg::ACT_INS_FRONT, isq_pkg::ACT_APPEND, isq_pkg::ACT_INS_AT: begin
                if (req_reg.action == isq_pkg::ACT_INS_FRONT)   p_w = '0;
                else if (req_reg.action == isq_pkg::ACT_APPEND) p_w = len_w;
                if (p_w > len_w)                   dec_st = isq_pkg::ST_RANGE;
                else if (len_w >= W'(CAPACITY))    dec_st = isq_pkg::ST_FULL;
                else                               dec_op = isq_pkg::OP_INS;
            end
            isq_pkg::ACT_DELETE: begin
                if (pos_w < len_w) dec_op = isq_pkg::OP_DEL;
                else               dec_st = isq_pkg::ST_RANGE;
            end
            default: begin
                dec_op = isq_pkg::OP_NONE;
            end
        endcase
    end

    assign stat.dec_op = dec_op;
    assign stat.more   = (op_reg == isq_pkg::OP_INS) ? (ptr_reg > p_reg)
                                                     : (ptr_ext < {1'b0, len_reg});

    // memory addressing
    always_comb begin
        case (op_reg)
            isq_pkg::OP_READ: raddr = pos_w[IDX_W-1:0];
            isq_pkg::OP_INS:  raddr = ptr_m1[IDX_W-1:0];
            default:          raddr = ptr_p1[IDX_W-1:0];
        endcase
        we    = cmd.shift_wr || (cmd.commit && op_reg == isq_pkg::OP_INS);
        waddr = cmd.shift_wr ? ptr_reg[IDX_W-1:0] : p_reg[IDX_W-1:0];
        wdata = cmd.shift_wr ? rd_data_reg : req_reg.item_value;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_comb begin
        len_next = len_reg;
        if (cmd.commit) begin
            if (op_reg == isq_pkg::OP_INS)      len_next = len_reg + {{(LEN_W-1){1'b0}}, 1'b1};
            else if (op_reg == isq_pkg::OP_DEL) len_next = len_reg - {{(LEN_W-1){1'b0}}, 1'b1};
        end
        ptr_next = ptr_reg;
        if (cmd.decode) begin
            ptr_next = (dec_op == isq_pkg::OP_INS) ? len_reg : LEN_W'(pos_w);
        end else if (cmd.shift_wr) begin
            ptr_next = (op_reg == isq_pkg::OP_INS) ? ptr_m1 : ptr_p1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            op_reg  <= isq_pkg::OP_NONE;
        end else begin
            len_reg <= len_next;
            if (cmd.decode) op_reg <= dec_op;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.capture) req_reg <= s_word;
        if (cmd.decode) begin
            st_reg <= dec_st;
            p_reg  <= LEN_W'(p_w);
        end
        if (cmd.load_out) begin
            out_reg.read_value <= (op_reg == isq_pkg::OP_READ) ? rd_data_reg : '1;
            out_reg.status     <= st_reg;
            out_reg.length_now <= 7'(len_reg);
        end
    end

    assign m_word = out_reg;

endmodule

FILE: rtl/core/isq_ctrl.sv
// isq_ctrl: sequencer for decode, memory read and one-place shifting
// depends on isq_pkg
module isq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  isq_pkg::isq_stat_t   stat,
    output isq_pkg::isq_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DECODE   = 6'b000010,
        S_READ_MEM = 6'b000100,
        S_SHIFT_RD = 6'b001000,
        S_SHIFT_WR = 6'b010000,
        S_FINISH   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                case (stat.dec_op)
                    isq_pkg::OP_READ: state_next = S_READ_MEM;
                    isq_pkg::OP_NONE: state_next = S_FINISH;
                    default:          state_next = S_SHIFT_RD;
                endcase
            end
            S_READ_MEM: begin
                cmd.mem_rd = 1'b1;
                state_next = S_FINISH;
            end
            S_SHIFT_RD: begin
                if (stat.more) begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_SHIFT_WR;
                end else begin
                    cmd.commit = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out)  m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/core/indexed_sequence_store.sv
// indexed_sequence_store: top level, depends on isq_pkg, isq_ctrl and isq_datapath
// steps: a valid read passes decode and a memory read, then its result word is registered;
//   a rejected request or unused action goes from decode to the result; insert/delete move
//   k entries (at most CAPACITY - 1), each by a memory read state then a write state
// throughput: one request at a time, next word taken the cycle after the result is registered
// reset: synchronous active-low aresetn empties the store (length 0), memory not cleared
module indexed_sequence_store #(
    parameter int CAPACITY = isq_pkg::CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  isq_pkg::in_word_t    s_word,
    // result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output isq_pkg::out_word_t   m_word
);

    // command and status between the sequencer and the datapath
    isq_pkg::isq_cmd_t  cmd;
    isq_pkg::isq_stat_t stat;

    // sequencer: decode, single read, and the shift loop over the entry memory
    isq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: holds the entries, the length, the request and the output register
    isq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .stat    (stat),
        .m_word  (m_word)
    );

endmodule

FILE: rtl/core/isq_checker.sv
// isq_checker: port-level checks on the indexed sequence store, bound to the top level
// depends on isq_pkg
module isq_checker #(
    parameter int CAPACITY = isq_pkg::CAPACITY_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input isq_pkg::in_word_t    s_word,
    input logic                 m_valid,
    input logic                 m_ready,
    input isq_pkg::out_word_t   m_word
);

    // a waiting request word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_word))
        else $error("request word changed while waiting");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in flight");

    // a refused insert on a full store reports full length
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status == isq_pkg::ST_FULL |-> m_word.length_now == 7'(CAPACITY))
        else $error("full status with length below capacity");

    // failed requests never return data
    a_fail_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status != isq_pkg::ST_DONE |-> m_word.read_value == -32'sd1)
        else $error("failed request returned a value");

endmodule

bind indexed_sequence_store isq_checker #(.CAPACITY(CAPACITY)) u_isq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_word  (s_word),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
